@@ rtl/anf_q14_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package anf_q14_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;
    localparam logic [CFG_INDEX_W-1:0] REG_POLE_RADIUS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POLE_RADIUS_SQ = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE      = 2'd2;

    localparam logic [CFG_DATA_W-1:0] POLE_RADIUS_RESET    = 15'd29491;
    localparam logic [CFG_DATA_W-1:0] POLE_RADIUS_SQ_RESET = 15'd26542;
    localparam logic [CFG_DATA_W-1:0] STEP_SIZE_RESET      = 15'd0;

    localparam int SAMPLE_W = 16;

    // fixed-point scaling shifts
    localparam int T0_SHIFT  = 29;   // rho * a * s1
    localparam int T1_SHIFT  = 15;   // rho2 * s2
    localparam int E_SHIFT   = 14;   // a * s1
    localparam int UPD_SHIFT = 30;   // s1 * e * mu

    // coefficient step, signed Q13
    localparam int UPD_W   = 14;
    localparam int UPD_MAX = (1 << 13) - 1;
    localparam int UPD_MIN = -(1 << 13);

    // microprogram
    localparam int STEP_W   = 4;
    localparam int PROG_LEN = 14;
    localparam logic [STEP_W-1:0] STEP_START  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_COMMIT = 4'd13;
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(PROG_LEN - 1);

    typedef enum logic [2:0] {
        MA_COEFF,
        MA_S1,
        MA_RHO,
        MA_RHO2,
        MA_MU
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_S1,
        MB_S2,
        MB_PLO,
        MB_PHI,
        MB_E
    } mul_b_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,     // latch the input sample
        OP_P_LOAD,      // partial product register <= product
        OP_T1,          // feedback term <= product >>> 15
        OP_ACC_LOAD,    // accumulator <= product
        OP_ACC_ADDHI,   // accumulator += product << DW
        OP_SK,          // new history value
        OP_E,           // notch output
        OP_COMMIT       // coefficient, history and result register
    } alu_op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN,        // hold until an input transaction
        COND_OUT        // hold until the result register is free
    } cond_t;

    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        alu_op_t alu;
        cond_t   cond;
        logic    restart;
    } ctrl_t;

    // The ALU field consumes the product registered by the previous step.
    function automatic ctrl_t microcode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{mul_a: MA_COEFF, mul_b: MB_S1, alu: OP_NONE, cond: COND_ALWAYS,
              restart: 1'b0};
        unique case (step)
            4'd0:  begin w.alu = OP_CAPTURE; w.cond = COND_IN; end
            4'd1:  begin w.mul_a = MA_COEFF; w.mul_b = MB_S1; end
            4'd2:  begin w.mul_a = MA_RHO2; w.mul_b = MB_S2; w.alu = OP_P_LOAD; end
            4'd3:  begin w.mul_a = MA_RHO; w.mul_b = MB_PLO; w.alu = OP_T1; end
            4'd4:  begin w.mul_a = MA_RHO; w.mul_b = MB_PHI; w.alu = OP_ACC_LOAD; end
            4'd5:  w.alu = OP_ACC_ADDHI;
            4'd6:  w.alu = OP_SK;
            4'd7:  w.alu = OP_E;
            4'd8:  begin w.mul_a = MA_S1; w.mul_b = MB_E; end
            4'd9:  w.alu = OP_P_LOAD;
            4'd10: begin w.mul_a = MA_MU; w.mul_b = MB_PLO; end
            4'd11: begin w.mul_a = MA_MU; w.mul_b = MB_PHI; w.alu = OP_ACC_LOAD; end
            4'd12: w.alu = OP_ACC_ADDHI;
            4'd13: begin w.alu = OP_COMMIT; w.cond = COND_OUT; w.restart = 1'b1; end
            default: w.restart = 1'b1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/adaptive_notch_filter_q14.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                      payload
// -------   ---------  -----------------------------  --------------------------
// input     in         in_valid / in_ready            sample_in  (s16, Q15)
// result    out        out_valid / out_ready          error_out, coeff_out (s16, Q14)
// config    in         cfg_write_en, no handshake     cfg_index (2b), cfg_data (15b)
//
// A result is registered at the commit step: a 14-step microprogram
// drives one shared (DATA_WIDTH+1)-square signed multiplier, seven products per sample.
// in_ready is high only in the first step; the next sample can be taken the cycle
// after the result is loaded, so no sample is accepted while one is in flight.
// The last step holds while the result register is full and not being taken.
// Reset clears history, coefficient and sequencer and loads register defaults.

module adaptive_notch_filter_q14
    import anf_q14_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,

    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  signed [SAMPLE_W-1:0]   sample_in,

    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [SAMPLE_W-1:0]   error_out,
    output logic signed [SAMPLE_W-1:0]   coeff_out,

    input  wire                          cfg_write_en,
    input  wire         [CFG_INDEX_W-1:0] cfg_index,
    input  wire         [CFG_DATA_W-1:0] cfg_data
);

    localparam int DW  = DATA_WIDTH;
    localparam int MW  = DW + 1;                 // multiplier operand width
    localparam int PRW = 2 * MW;                 // multiplier product width
    localparam int WW  = 2 * DW + 16;            // exact width of triple products
    localparam int PW  = (WW > 64) ? 64 : WW;    // products wrap at 64 bits
    localparam int UW  = PW - UPD_SHIFT;         // width of the update before clamp

    localparam logic signed [UW-1:0] U_MAX = UW'(UPD_MAX);
    localparam logic signed [UW-1:0] U_MIN = UW'(UPD_MIN);

    // sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_t             ctrl;
    logic              advance;
    logic              out_free;

    // configuration
    logic [CFG_DATA_W-1:0] rho_reg, rho_next;
    logic [CFG_DATA_W-1:0] rho2_reg, rho2_next;
    logic [CFG_DATA_W-1:0] mu_reg, mu_next;

    // filter state; the three-entry circular history is kept as a two-tap
    // shift line, since only the two newest entries are ever read
    logic [DW-1:0] hist1_reg, hist1_next;    // s1, newest
    logic [DW-1:0] hist2_reg, hist2_next;    // s2
    logic [DW-1:0] coeff_reg, coeff_next;

    // datapath
    logic signed [SAMPLE_W-1:0] y_reg, y_next;
    logic signed [MW-1:0]       op_a, op_b;
    logic signed [PRW-1:0]      prod_reg, prod_next;
    logic [2*DW-1:0]            p_reg, p_next;
    logic [DW-1:0]              t1_reg, t1_next;
    logic signed [WW-1:0]       acc_reg, acc_next;
    logic [DW-1:0]              sk_reg, sk_next;
    logic [DW-1:0]              e_reg, e_next;
    logic signed [DW-1:0]       y_wide;
    logic signed [DW-1:0]       y_half;
    logic signed [UW-1:0]       u_raw;
    logic signed [UW-1:0]       u_clamped;
    logic signed [UPD_W-1:0]    upd;
    logic signed [DW-1:0]       upd_wide;
    logic [DW-1:0]              coeff_new;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] error_out_reg, error_out_next;
    logic signed [SAMPLE_W-1:0] coeff_out_reg, coeff_out_next;

    assign ctrl     = microcode(step_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (ctrl.cond == COND_IN);

    assign out_valid = out_valid_reg;
    assign error_out = error_out_reg;
    assign coeff_out = coeff_out_reg;

    always_comb
    begin
        unique case (ctrl.cond)
            COND_ALWAYS: advance = 1'b1;
            COND_IN:     advance = in_valid;
            COND_OUT:    advance = out_free;
            default:     advance = 1'b1;
        endcase
        if (!advance)
            step_next = step_reg;
        else if (ctrl.restart)
            step_next = STEP_START;
        else
            step_next = step_reg + 1'b1;
    end

    // shared multiplier operands
    always_comb
    begin
        unique case (ctrl.mul_a)
            MA_COEFF: op_a = $signed({coeff_reg[DW-1], coeff_reg});
            MA_S1:    op_a = $signed({hist1_reg[DW-1], hist1_reg});
            MA_RHO:   op_a = $signed({{(MW-CFG_DATA_W){1'b0}}, rho_reg});
            MA_RHO2:  op_a = $signed({{(MW-CFG_DATA_W){1'b0}}, rho2_reg});
            MA_MU:    op_a = $signed({{(MW-CFG_DATA_W){1'b0}}, mu_reg});
            default:  op_a = '0;
        endcase
        unique case (ctrl.mul_b)
            MB_S1:   op_b = $signed({hist1_reg[DW-1], hist1_reg});
            MB_S2:   op_b = $signed({hist2_reg[DW-1], hist2_reg});
            MB_PLO:  op_b = $signed({1'b0, p_reg[DW-1:0]});
            MB_PHI:  op_b = $signed({p_reg[2*DW-1], p_reg[2*DW-1:DW]});
            MB_E:    op_b = $signed({e_reg[DW-1], e_reg});
            default: op_b = '0;
        endcase
        prod_next = op_a * op_b;
    end

    // coefficient update: clamp to signed Q13, then double
    always_comb
    begin
        u_raw = $signed(acc_reg[PW-1:UPD_SHIFT]);
        if (u_raw > U_MAX)
            u_clamped = U_MAX;
        else if (u_raw < U_MIN)
            u_clamped = U_MIN;
        else
            u_clamped = u_raw;
        upd       = $signed(u_clamped[UPD_W-1:0]);
        upd_wide  = DW'(upd);
        coeff_new = coeff_reg + {upd_wide[DW-2:0], 1'b0};
    end

    // ALU and state update
    always_comb
    begin
        y_wide = DW'(y_reg);
        y_half = y_wide >>> 1;

        y_next         = y_reg;
        p_next         = p_reg;
        t1_next        = t1_reg;
        acc_next       = acc_reg;
        sk_next        = sk_reg;
        e_next         = e_reg;
        hist1_next     = hist1_reg;
        hist2_next     = hist2_reg;
        coeff_next     = coeff_reg;
        error_out_next = error_out_reg;
        coeff_out_next = coeff_out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (advance)
        begin
            unique case (ctrl.alu)
                OP_NONE:      ;
                OP_CAPTURE:   y_next = sample_in;
                OP_P_LOAD:    p_next = prod_reg[2*DW-1:0];
                OP_T1:        t1_next = prod_reg[DW+T1_SHIFT-1:T1_SHIFT];
                OP_ACC_LOAD:  acc_next = WW'(prod_reg);
                OP_ACC_ADDHI: acc_next = acc_reg + (WW'(prod_reg) <<< DW);
                // only the low DW bits of the sum survive, so the terms are cut first
                OP_SK:        sk_next = y_half + acc_reg[DW+T0_SHIFT-1:T0_SHIFT] - t1_reg;
                OP_E:         e_next = sk_reg - p_reg[DW+E_SHIFT-1:E_SHIFT] + hist2_reg;
                OP_COMMIT:
                begin
                    coeff_next     = coeff_new;
                    hist2_next     = hist1_reg;
                    hist1_next     = sk_reg;
                    error_out_next = e_reg[SAMPLE_W-1:0];
                    coeff_out_next = coeff_new[SAMPLE_W-1:0];
                    out_valid_next = 1'b1;
                end
                default:      ;
            endcase
        end
    end

    // configuration writes; unknown indexes are dropped
    always_comb
    begin
        rho_next  = rho_reg;
        rho2_next = rho2_reg;
        mu_next   = mu_reg;
        if (cfg_write_en)
        begin
            if (cfg_index == REG_POLE_RADIUS)
                rho_next = cfg_data;
            else if (cfg_index == REG_POLE_RADIUS_SQ)
                rho2_next = cfg_data;
            else if (cfg_index == REG_STEP_SIZE)
                mu_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_START;
            out_valid_reg <= 1'b0;
            rho_reg       <= POLE_RADIUS_RESET;
            rho2_reg      <= POLE_RADIUS_SQ_RESET;
            mu_reg        <= STEP_SIZE_RESET;
            hist1_reg     <= '0;
            hist2_reg     <= '0;
            coeff_reg     <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            rho_reg       <= rho_next;
            rho2_reg      <= rho2_next;
            mu_reg        <= mu_next;
            hist1_reg     <= hist1_next;
            hist2_reg     <= hist2_next;
            coeff_reg     <= coeff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg         <= y_next;
        prod_reg      <= prod_next;
        p_reg         <= p_next;
        t1_reg        <= t1_next;
        acc_reg       <= acc_next;
        sk_reg        <= sk_next;
        e_reg         <= e_next;
        error_out_reg <= error_out_next;
        coeff_out_reg <= coeff_out_next;
    end

    // one sample at a time: an accepted sample closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // a result appears only from the commit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step_reg) == STEP_COMMIT)
        else $error("result raised outside the commit step");

    // the step counter stays inside the microprogram
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("step counter outside the program");

endmodule

`default_nettype wire

@@ verif/anf_q14_checker.sv @@
`timescale 1ns / 1ps

// Watches the sample, result and register ports of the notch filter, keeps its
// own copy of the filter state and compares every result transaction in order.
module anf_q14_checker
    import anf_q14_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,

    input  wire                          in_valid,
    input  wire                          in_ready,
    input  wire  signed [SAMPLE_W-1:0]   sample_in,

    input  wire                          out_valid,
    input  wire                          out_ready,
    input  wire  signed [SAMPLE_W-1:0]   error_out,
    input  wire  signed [SAMPLE_W-1:0]   coeff_out,

    input  wire                          cfg_write_en,
    input  wire         [CFG_INDEX_W-1:0] cfg_index,
    input  wire         [CFG_DATA_W-1:0] cfg_data,

    output int                           fail_count,
    output int                           pending,
    output int                           checked
);

    localparam int MAX_REPORTS = 100;

    typedef struct {
        logic signed [SAMPLE_W-1:0] err;
        logic signed [SAMPLE_W-1:0] coeff;
    } notch_result_t;

    notch_result_t predicted_outputs[$];

    // filter state, with the history kept as a three-entry ring
    logic signed [SAMPLE_W-1:0] hist [3];
    logic signed [SAMPLE_W-1:0] coeff_q;
    logic        [1:0]          wr_pos;
    logic        [CFG_DATA_W-1:0] rho_q;
    logic        [CFG_DATA_W-1:0] rho2_q;
    logic        [CFG_DATA_W-1:0] mu_q;

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    task automatic report_mismatch(input string line);
        if (fail_count < MAX_REPORTS)
            $display("%0t ns  mismatch: %s", $realtime, line);
        fail_count++;
    endtask

    // One sample through the recursion, error and LMS coefficient update.
    task automatic advance_notch(input logic signed [SAMPLE_W-1:0] y,
                                 output notch_result_t r);
        int unsigned k;
        int unsigned k1;
        int unsigned k2;
        longint yl, s1, s2, a, rl, r2l, ml, t0, t1, acc, step;
        logic signed [SAMPLE_W-1:0] sk;
        logic signed [SAMPLE_W-1:0] e;
        logic signed [SAMPLE_W-1:0] c;
        k   = (wr_pos > 2'd2) ? 0 : wr_pos;
        k1  = (k + 2) % 3;
        k2  = (k + 1) % 3;
        yl  = y;
        s1  = hist[k1];
        s2  = hist[k2];
        a   = coeff_q;
        rl  = rho_q;
        r2l = rho2_q;
        ml  = mu_q;

        t0  = (rl * a * s1) >>> T0_SHIFT;
        t1  = (r2l * s2) >>> T1_SHIFT;
        acc = (yl >>> 1) + t0 - t1;
        sk  = acc[SAMPLE_W-1:0];
        hist[k] = sk;

        acc = longint'(sk) - ((a * s1) >>> E_SHIFT) + s2;
        e   = acc[SAMPLE_W-1:0];

        // wrapped error feeds the update
        step = (s1 * longint'(e) * ml) >>> UPD_SHIFT;
        if (step > UPD_MAX)
            step = UPD_MAX;
        else if (step < UPD_MIN)
            step = UPD_MIN;
        acc = a + 2 * step;
        c   = acc[SAMPLE_W-1:0];
        coeff_q = c;

        wr_pos  = 2'((k + 1) % 3);
        r.err   = e;
        r.coeff = c;
    endtask

    always @(posedge clk) begin : watch
        notch_result_t want;
        if (!rst_n) begin
            hist[0] = '0;
            hist[1] = '0;
            hist[2] = '0;
            coeff_q = '0;
            wr_pos  = '0;
            rho_q   = POLE_RADIUS_RESET;
            rho2_q  = POLE_RADIUS_SQ_RESET;
            mu_q    = STEP_SIZE_RESET;
            predicted_outputs.delete();
            pending <= 0;
        end
        else begin
            if (cfg_write_en) begin
                case (cfg_index)
                    REG_POLE_RADIUS:    rho_q  = cfg_data;
                    REG_POLE_RADIUS_SQ: rho2_q = cfg_data;
                    REG_STEP_SIZE:      mu_q   = cfg_data;
                    default: ;
                endcase
            end

            // results first: a result never belongs to a sample taken at the same edge
            if (out_valid && out_ready) begin
                if (predicted_outputs.size() == 0) begin
                    report_mismatch($sformatf("result with no sample outstanding (e=%0d a=%0d)",
                                              error_out, coeff_out));
                end
                else begin
                    want = predicted_outputs.pop_front();
                    checked++;
                    if (error_out !== want.err)
                        report_mismatch($sformatf("result %0d error_out %0d, expected %0d",
                                                  checked, error_out, want.err));
                    if (coeff_out !== want.coeff)
                        report_mismatch($sformatf("result %0d coeff_out %0d, expected %0d",
                                                  checked, coeff_out, want.coeff));
                end
            end

            if (in_valid && in_ready) begin
                advance_notch(sample_in, want);
                predicted_outputs.push_back(want);
            end

            pending <= predicted_outputs.size();
        end
    end

endmodule

@@ verif/tb_adaptive_notch_filter_q14.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the adaptive notch filter. All prediction and
// comparison lives in anf_q14_checker; this module only drives the ports.
module tb_adaptive_notch_filter_q14;
    import anf_q14_pkg::*;

    // index 3 decodes to no register; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam int STALL_LIMIT     = 2000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES    = 42;    // idle time before the verdict
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int NUM_DIRECTED    = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    wire                           in_ready;
    logic signed [SAMPLE_W-1:0]    sample_in = '0;

    wire                           out_valid;
    logic                          out_ready = 1'b0;
    wire  signed [SAMPLE_W-1:0]    error_out;
    wire  signed [SAMPLE_W-1:0]    coeff_out;

    logic                          cfg_write_en = 1'b0;
    logic        [CFG_INDEX_W-1:0] cfg_index = '0;
    logic        [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int checked;

    int stall_pct = 0;      // receiver: chance per cycle of holding out_ready low
    int sender_pct = 0;     // sender: chance per cycle of an idle gap
    int samples_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    int directed [NUM_DIRECTED];

    adaptive_notch_filter_q14 uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .error_out    (error_out),
        .coeff_out    (coeff_out),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    anf_q14_checker notch_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .error_out    (error_out),
        .coeff_out    (coeff_out),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: fresh ready decision every cycle; out_ready holds the microprogram
    // only at its commit step, while the result register is full.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: a hung handshake shows up as a long run with no transaction.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // One input transaction. Valid is raised with the payload and held, untouched,
    // until the edge where in_ready was also high. Signals read right after the
    // edge still carry their pre-edge values, so that edge is the accept edge.
    task automatic drive_sample(input logic signed [SAMPLE_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Wait until every predicted result has been taken. The checker's count
    // is registered, hence the leading edge.
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
    endtask

    // All three registers, then a stray write to the undecoded index that
    // must leave them alone.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] rho,
                                input logic [CFG_DATA_W-1:0] rho2,
                                input logic [CFG_DATA_W-1:0] mu);
        write_reg(REG_POLE_RADIUS, rho);
        write_reg(REG_POLE_RADIUS_SQ, rho2);
        write_reg(REG_STEP_SIZE, mu);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_write_en <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        int phase;
        int sent;
        int kind;
        int len;
        int per;
        int amp;
        int nz;
        int pos;
        int val;
        int shape;
        int rho;
        logic [CFG_DATA_W-1:0] r0;
        logic [CFG_DATA_W-1:0] r1;
        logic [CFG_DATA_W-1:0] r2;

        // full-scale steps, sign flips, zero, one LSB either side, mid-scale
        // and alternating bit patterns
        directed = '{32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 1, -1,
                     16384, -16384, 21845, -21846, 32767, -32768, 32767, -32768,
                     12345, -1};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: largest radius, no feedback, largest step size. The update
        // can saturate and the coefficient and history can wrap, so the
        // wrapped error is what drives the next update.
        program_regs(15'd32767, 15'd0, 15'd32767);
        for (int i = 0; i < NUM_DIRECTED; i++)
            drive_sample(SAMPLE_W'(directed[i]));
        in_valid <= 1'b0;
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // pacing: none, sender gaps, receiver stalls, both
            case (phase % 4)
                0: begin sender_pct = 0;  stall_pct <= 0;  end
                1: begin sender_pct = 54; stall_pct <= 0;  end
                2: begin sender_pct = 0;  stall_pct <= 54; end
                default: begin sender_pct = 35; stall_pct <= 35; end
            endcase

            case (phase)
                0: begin r0 = '0; r1 = '0; r2 = '0; end
                1: begin r0 = '1; r1 = '1; r2 = '1; end
                2: begin
                    r0 = POLE_RADIUS_RESET;
                    r1 = POLE_RADIUS_SQ_RESET;
                    r2 = CFG_DATA_W'($urandom_range(1, 64));
                end
                3, 5, 6: begin
                    // narrow notch: rho near one, rho2 consistent, modest mu
                    rho = $urandom_range(26000, 32767);
                    r0  = CFG_DATA_W'(rho);
                    r1  = CFG_DATA_W'((rho * rho) >> 15);
                    r2  = CFG_DATA_W'($urandom_range(0, 2000));
                end
                default: begin
                    r0 = CFG_DATA_W'($urandom_range(0, 32767));
                    r1 = CFG_DATA_W'($urandom_range(0, 32767));
                    r2 = CFG_DATA_W'($urandom_range(0, 32767));
                end
            endcase
            program_regs(r0, r1, r2);

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                kind = $urandom_range(0, 9);
                if (kind <= 1) begin
                    // broadband noise, every bit pattern
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len && sent < ITEMS_PER_PHASE; i++) begin
                        drive_sample(SAMPLE_W'($urandom_range(0, 65535)));
                        sent++;
                    end
                end
                else if (kind == 2) begin
                    // rails and the values next to zero
                    len = $urandom_range(1, 4);
                    for (int i = 0; i < len && sent < ITEMS_PER_PHASE; i++) begin
                        case ($urandom_range(0, 3))
                            0: val = 32767;
                            1: val = -32768;
                            2: val = 0;
                            default: val = -1;
                        endcase
                        drive_sample(SAMPLE_W'(val));
                        sent++;
                    end
                end
                else begin
                    // Tone burst with light noise: the case the filter is built
                    // for, so the coefficient actually converges and tracks.
                    per   = $urandom_range(3, 48);
                    amp   = $urandom_range(0, 32767);
                    nz    = $urandom_range(0, 255);
                    shape = $urandom_range(0, 1);
                    len   = $urandom_range(8, 48);
                    for (int i = 0; i < len && sent < ITEMS_PER_PHASE; i++) begin
                        pos = i % per;
                        if (shape == 0)
                            val = (2 * pos < per) ? amp : -amp;
                        else
                            val = (2 * pos < per) ? -amp + (4 * amp * pos) / per
                                                  : 3 * amp - (4 * amp * pos) / per;
                        val = val + int'($urandom_range(0, 2 * nz)) - nz;
                        if (val > 32767)
                            val = 32767;
                        else if (val < -32768)
                            val = -32768;
                        drive_sample(SAMPLE_W'(val));
                        sent++;
                    end
                end
            end
            in_valid <= 1'b0;
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples over %0d register settings and four pacing modes;",
                 samples_sent, settings_used);
        $display("%0d results compared, %0d mismatches, %0d still outstanding.",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ adaptive_notch_filter_q14.f @@
rtl/anf_q14_pkg.sv
rtl/adaptive_notch_filter_q14.sv
verif/anf_q14_checker.sv
verif/tb_adaptive_notch_filter_q14.sv
